### design/heat_stencil_relaxation_assert.svh
// Assertion macros for the heat stencil relaxation block
`ifndef HEAT_STENCIL_RELAXATION_ASSERT_SVH
`define HEAT_STENCIL_RELAXATION_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define HSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsr assertion failed");

// next-cycle implication
`define HSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsr assertion failed");

`endif

### design/hsr_pkg.sv
// Package: constants, types and codes of the heat stencil relaxation block
package hsr_pkg;
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int AW       = $clog2(CELLS);
    localparam int WDIR     = 9598;
    localparam int WDIAG    = 6786;
    localparam int QONE     = 65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_STATS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SRC_INIT,
        SRC_G0,
        SRC_G1
    } t_src;

    typedef enum logic [1:0] {
        REG_THRESHOLD,
        REG_MAX_ITER,
        REG_ROWS,
        REG_COLS
    } t_reg;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;
endpackage

### design/heat_stencil_relaxation.sv
// Top level: heat stencil relaxation with load, sequencer and statistics
//
//  channel | direction | handshake               | payload
//  in      | to block  | i_in_valid / o_in_stall  | temperature, conductivity, last_cell
//  out     | from block| o_out_valid / i_out_stall| iterations, min, max, sum, change, conv
//  cfg     | to block  | i_cfg_wr_en              | i_cfg_index, i_cfg_data
//
// Loading accepts one cell per cycle while the block is idle. Each cell of each step is
// handled as nine reads through one memory read port, then seven steps of the shared
// multiplier; a statistics pass over the grid follows the last step.
// Input stalls for the whole run; the result register waits on i_out_stall.
// Reset is synchronous, active low; grid memories are not cleared.
module heat_stencil_relaxation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_cell_temperature,
    input  logic [16:0]         i_cell_conductivity,
    input  logic                i_last_cell,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [23:0]         o_iterations_done,
    output logic signed [31:0]  o_min_temp,
    output logic signed [31:0]  o_max_temp,
    output logic signed [43:0]  o_sum_temp,
    output logic [30:0]         o_max_change,
    output logic                o_converged,
    input  logic                i_cfg_wr_en,
    input  hsr_pkg::t_reg       i_cfg_index,
    input  logic [30:0]         i_cfg_data
);
    import hsr_pkg::*;

    `include "heat_stencil_relaxation_assert.svh"

    t_state r_state, n_state;
    t_mac_ctl mac_ctl;

    logic [30:0] r_threshold;
    logic [23:0] r_max_iter;
    logic [6:0]  r_rows, r_cols;
    logic [AW:0] r_lp;

    logic [6:0]  r_R, r_C;
    logic [AW:0] r_rc;
    logic [23:0] r_maxit, r_steps;
    logic [5:0]  r_r, r_c;
    logic [AW-1:0] r_rb;
    logic [3:0]  r_j;
    logic [2:0]  r_m;
    logic        r_first, r_cur;
    logic [32:0] r_maxd;
    logic        r_conv;

    logic signed [31:0] r_o;
    logic signed [33:0] r_sd, r_sg;
    logic [16:0]        r_kc;
    logic signed [34:0] r_nb;

    logic [AW:0]        r_p;
    logic signed [31:0] r_min, r_max;
    logic signed [44:0] r_sum;

    logic               r_out_valid;
    logic [23:0]        r_o_iter;
    logic signed [31:0] r_o_min, r_o_max;
    logic signed [43:0] r_o_sum;
    logic [30:0]        r_o_chg;
    logic               r_o_conv;

    t_src        r_rsel;
    logic        r_rmask, r_kmask;

    logic        in_acc, load_we;
    logic [16:0] k_sat;
    logic [6:0]  rows_cl, cols_cl;
    logic [23:0] maxit_cl;

    logic [5:0]  cl, cr, col;
    logic        bot_row, end_row, end_step, dst_g1;
    t_src        src, rmem;
    logic [AW:0] base;
    logic [AW-1:0] raddr, idx;

    logic [31:0] init_q, g0_q, g1_q;
    logic [16:0] k_q;
    logic signed [31:0] rd;
    logic [16:0] kc;

    logic signed [35:0] op_a;
    logic signed [17:0] op_b;
    logic signed [39:0] mac_round;
    logic signed [31:0] nv;
    logic signed [32:0] d;
    logic [32:0] absd;
    logic        conv_now;
    logic [32:0] maxd_now;
    logic        steps_done;
    logic        out_load;
    logic signed [43:0] sum_sat;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign load_we = in_acc && !r_lp[AW];
    assign k_sat   = (i_cell_conductivity > 17'(QONE)) ? 17'(QONE) : i_cell_conductivity;

    assign rows_cl  = (r_rows == 7'd0) ? 7'd1 :
                      (r_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : r_rows;
    assign cols_cl  = (r_cols < 7'd2) ? 7'd2 :
                      (r_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : r_cols;
    assign maxit_cl = (r_max_iter == 24'd0) ? 24'd1 : r_max_iter;

    // neighbour addressing
    assign cl       = (r_c == 6'd0) ? 6'(r_C - 7'd1) : r_c - 6'd1;
    assign cr       = (r_c == 6'(r_C - 7'd1)) ? 6'd0 : r_c + 6'd1;
    assign bot_row  = (r_r == 6'(r_R - 7'd1));
    assign end_row  = (r_c == 6'(r_C - 7'd1));
    assign end_step = end_row && bot_row;
    assign dst_g1   = !r_first && !r_cur;
    assign src      = r_first ? SRC_INIT : (r_cur ? SRC_G1 : SRC_G0);
    assign idx      = AW'({1'b0, r_rb} + {{(AW + 1 - 6){1'b0}}, r_c});

    always_comb begin
        col  = r_c;
        base = {1'b0, r_rb};
        rmem = src;
        case (r_j) inside
            4'd1, 4'd5, 4'd7: col = cl;
            4'd2, 4'd6, 4'd8: col = cr;
            default:          col = r_c;
        endcase
        case (r_j) inside
            4'd3, 4'd5, 4'd6: begin
                if (r_r == 6'd0) begin
                    base = '0;
                    rmem = SRC_INIT;
                end else begin
                    base = {1'b0, r_rb} - {{(AW + 1 - 7){1'b0}}, r_C};
                end
            end
            4'd4, 4'd7, 4'd8: begin
                if (bot_row) begin
                    rmem = SRC_INIT;
                end else begin
                    base = {1'b0, r_rb} + {{(AW + 1 - 7){1'b0}}, r_C};
                end
            end
            default: base = {1'b0, r_rb};
        endcase
        raddr = AW'(base + {{(AW + 1 - 6){1'b0}}, col});
        if (r_state == S_STATS) begin
            raddr = r_p[AW-1:0];
            rmem  = r_cur ? SRC_G1 : SRC_G0;
        end
    end

    hsr_ram #(.W(32), .AW(AW)) u_init (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(r_lp[AW-1:0]),
        .i_wdata(i_cell_temperature), .i_raddr(raddr), .o_rdata(init_q)
    );
    hsr_ram #(.W(17), .AW(AW)) u_kmem (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(r_lp[AW-1:0]),
        .i_wdata(k_sat), .i_raddr(idx), .o_rdata(k_q)
    );
    hsr_ram #(.W(32), .AW(AW)) u_g0 (
        .i_clk(i_clk), .i_we(r_state == S_MAC && r_m == 3'd6 && !dst_g1),
        .i_waddr(idx), .i_wdata(nv), .i_raddr(raddr), .o_rdata(g0_q)
    );
    hsr_ram #(.W(32), .AW(AW)) u_g1 (
        .i_clk(i_clk), .i_we(r_state == S_MAC && r_m == 3'd6 && dst_g1),
        .i_waddr(idx), .i_wdata(nv), .i_raddr(raddr), .o_rdata(g1_q)
    );

    always_comb begin
        case (r_rsel)
            SRC_INIT: rd = r_rmask ? 32'sd0 : init_q;
            SRC_G0:   rd = g0_q;
            SRC_G1:   rd = g1_q;
            default:  rd = 32'sd0;
        endcase
    end
    assign kc = r_kmask ? 17'd0 : k_q;

    hsr_mac u_mac (
        .i_clk(i_clk), .i_ctl(mac_ctl), .i_op_a(op_a), .i_op_b(op_b), .o_round(mac_round)
    );

    assign nv = (mac_round > 40'sh007FFFFFFF) ? 32'sh7FFFFFFF :
                (mac_round < -40'sh0080000000) ? 32'sh80000000 : mac_round[31:0];
    assign d        = {r_o[31], r_o} - {nv[31], nv};
    assign absd     = d[32] ? 33'(-d) : 33'(d);
    assign conv_now = r_conv && (absd < {2'b00, r_threshold});
    assign maxd_now = (absd > r_maxd) ? absd : r_maxd;
    assign steps_done = (r_steps + 24'd1 >= r_maxit) || conv_now;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign sum_sat    = (r_sum > 45'sh07FFFFFFFFFF) ? 44'sh7FFFFFFFFFF :
                        (r_sum < -45'sh080000000000) ? 44'sh80000000000 : r_sum[43:0];

    // sequencer: next state and shared unit control
    always_comb begin
        n_state = r_state;
        mac_ctl = '0;
        op_a    = {{2{r_sd[33]}}, r_sd};
        op_b    = 18'(WDIR);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_last_cell) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_j == 4'd9) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                unique case (r_m)
                    3'd0: begin
                        mac_ctl.mul_en = 1'b1;
                    end
                    3'd1: begin
                        mac_ctl.mul_en   = 1'b1;
                        mac_ctl.acc_load = 1'b1;
                        op_a = {{2{r_sg[33]}}, r_sg};
                        op_b = 18'(WDIAG);
                    end
                    3'd2: mac_ctl.acc_add = 1'b1;
                    3'd3: begin
                        mac_ctl.mul_en = 1'b1;
                        op_a = {{4{r_o[31]}}, r_o};
                        op_b = {1'b0, r_kc};
                    end
                    3'd4: begin
                        mac_ctl.mul_en   = 1'b1;
                        mac_ctl.acc_load = 1'b1;
                        op_a = {r_nb[34], r_nb};
                        op_b = 18'(QONE) - {1'b0, r_kc};
                    end
                    3'd5: mac_ctl.acc_add = 1'b1;
                    3'd6: begin
                        if (!end_step) begin
                            n_state = S_READ;
                        end else if (steps_done) begin
                            n_state = S_STATS;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_STATS: begin
                if (r_p == r_rc) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 31'd6554;
            r_max_iter  <= 24'd1000;
            r_rows      <= 7'd64;
            r_cols      <= 7'd64;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_MAX_ITER:  r_max_iter  <= i_cfg_data[23:0];
                REG_ROWS:      r_rows      <= i_cfg_data[6:0];
                REG_COLS:      r_cols      <= i_cfg_data[6:0];
                default:       r_rows      <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp        <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
            r_conv      <= 1'b0;
            r_maxd      <= '0;
            r_j         <= '0;
            r_m         <= '0;
            r_p         <= '0;
            r_first     <= 1'b1;
            r_cur       <= 1'b0;
        end else begin
            r_rsel  <= rmem;
            r_rmask <= ({1'b0, raddr} >= r_lp);
            r_kmask <= ({1'b0, idx} >= r_lp);
            if (load_we) begin
                r_lp <= r_lp + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_last_cell) begin
                        r_R     <= rows_cl;
                        r_C     <= cols_cl;
                        r_rc    <= (AW + 1)'(rows_cl) * (AW + 1)'(cols_cl);
                        r_maxit <= maxit_cl;
                        r_steps <= '0;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_rb    <= '0;
                        r_j     <= '0;
                        r_first <= 1'b1;
                        r_cur   <= 1'b0;
                        r_maxd  <= '0;
                        r_conv  <= 1'b1;
                    end
                end
                S_READ: begin
                    r_j <= r_j + 4'd1;
                    case (r_j) inside
                        4'd0: begin
                            r_sd <= '0;
                            r_sg <= '0;
                        end
                        4'd1: begin
                            r_o  <= rd;
                            r_kc <= kc;
                        end
                        4'd2, 4'd3, 4'd4, 4'd5: r_sd <= r_sd + 34'(rd);
                        4'd6, 4'd7, 4'd8, 4'd9: r_sg <= r_sg + 34'(rd);
                        default: ;
                    endcase
                    if (r_j == 4'd9) begin
                        r_m <= '0;
                    end
                end
                S_MAC: begin
                    r_m <= r_m + 3'd1;
                    if (r_m == 3'd3) begin
                        r_nb <= mac_round[34:0];
                    end
                    if (r_m == 3'd6) begin
                        r_j <= '0;
                        if (end_step && !steps_done) begin
                            r_maxd <= '0;
                            r_conv <= 1'b1;
                        end else begin
                            r_maxd <= maxd_now;
                            r_conv <= conv_now;
                        end
                        if (!end_row) begin
                            r_c <= r_c + 6'd1;
                        end else if (!bot_row) begin
                            r_c  <= '0;
                            r_r  <= r_r + 6'd1;
                            r_rb <= r_rb + AW'(r_C);
                        end else begin
                            r_steps <= r_steps + 24'd1;
                            r_first <= 1'b0;
                            r_cur   <= dst_g1;
                            r_c     <= '0;
                            r_r     <= '0;
                            r_rb    <= '0;
                            r_p     <= '0;
                            r_min   <= 32'sh7FFFFFFF;
                            r_max   <= 32'sh80000000;
                            r_sum   <= '0;
                        end
                    end
                end
                S_STATS: begin
                    r_p <= r_p + 1'b1;
                    if (r_p != '0) begin
                        r_sum <= r_sum + 45'(rd);
                        if (rd < r_min) begin
                            r_min <= rd;
                        end
                        if (rd > r_max) begin
                            r_max <= rd;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_o_iter    <= r_steps;
                        r_o_min     <= r_min;
                        r_o_max     <= r_max;
                        r_o_sum     <= sum_sat;
                        r_o_chg     <= (r_maxd > 33'h07FFFFFFF) ? 31'h7FFFFFFF : r_maxd[30:0];
                        r_o_conv    <= r_conv;
                        r_lp        <= '0;
                    end
                end
                default: r_j <= '0;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_iterations_done = r_o_iter;
    assign o_min_temp        = r_o_min;
    assign o_max_temp        = r_o_max;
    assign o_sum_temp        = r_o_sum;
    assign o_max_change      = r_o_chg;
    assign o_converged       = r_o_conv;

    `HSR_ASSERT_IMP(a_steps_below_limit, r_state == S_MAC, r_steps < r_maxit)
    `HSR_ASSERT_IMP(a_stats_in_range, r_state == S_STATS, r_p <= r_rc)
    `HSR_ASSERT_IMP(a_conv_means_small,
        r_state == S_READ && r_conv && r_maxd != 33'd0, r_maxd < {2'b00, r_threshold})
    `HSR_ASSERT_NXT(a_result_issued, out_load, r_out_valid && r_lp == '0)
endmodule

### design/hsr_ram.sv
// Simple dual-port RAM with registered read
module hsr_ram #(
    parameter int W  = 32,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

### design/hsr_mac.sv
// Shared multiply-accumulate unit with round-half-up shift by 16
module hsr_mac (
    input  logic                 i_clk,
    input  hsr_pkg::t_mac_ctl    i_ctl,
    input  logic signed [35:0]   i_op_a,
    input  logic signed [17:0]   i_op_b,
    output logic signed [39:0]   o_round
);
    import hsr_pkg::*;

    logic signed [53:0] r_prod;
    logic signed [55:0] r_acc;
    logic signed [55:0] biased;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_load) begin
            r_acc <= 56'(r_prod);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + 56'(r_prod);
        end
    end

    assign biased  = r_acc + 56'sd32768;
    assign o_round = biased[55:16];
endmodule

### tb/hsr_checker.sv
// Checker: watches the item, result and register ports, predicts the statistics and compares
module hsr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic signed [31:0]  i_cell_temperature,
    input  logic [16:0]         i_cell_conductivity,
    input  logic                i_last_cell,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [23:0]         i_iterations_done,
    input  logic signed [31:0]  i_min_temp,
    input  logic signed [31:0]  i_max_temp,
    input  logic signed [43:0]  i_sum_temp,
    input  logic [30:0]         i_max_change,
    input  logic                i_converged,
    input  logic                i_cfg_wr_en,
    input  hsr_pkg::t_reg       i_cfg_index,
    input  logic [30:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import hsr_pkg::*;

    localparam int GRID_CELLS = (MAX_ROWS + 2) * MAX_COLS;
    localparam longint SUM_HI = 64'sd8796093022207;
    localparam longint SUM_LO = -64'sd8796093022208;

    typedef struct {
        logic [23:0]        iters;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic signed [43:0] sum;
        logic [30:0]        chg;
        logic               conv;
    } t_stats;

    t_stats      stats_q[$];
    longint      staged_temp[CELLS];
    longint      staged_cond[CELLS];
    longint      cur[GRID_CELLS];
    longint      nxt[GRID_CELLS];
    int unsigned load_pos;
    logic [30:0] thr;
    logic [23:0] iter_lim;
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;
    int          fails;

    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic t_stats relax_grid();
        t_stats s;
        int     nr, nc, rc, lim, steps;
        longint o, sd, sg, nb, kc, nv, d, maxd, mn, mx, sum;
        bit     conv;
        int     up, mid, dn, cl, cr;
        nr  = (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
        nc  = (cols_reg < 2) ? 2 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        rc  = nr * nc;
        lim = (iter_lim == 0) ? 1 : iter_lim;
        for (int p = load_pos; p < rc; p++) begin
            staged_temp[p] = 0;
            staged_cond[p] = 0;
        end
        for (int p = 0; p < rc; p++) cur[nc + p] = staged_temp[p];
        for (int c = 0; c < nc; c++) begin
            cur[c] = cur[nc + c];
            cur[(nr + 1) * nc + c] = cur[nr * nc + c];
        end
        steps = 0;
        do begin
            maxd = 0;
            conv = 1'b1;
            for (int r = 1; r <= nr; r++) begin
                up  = (r - 1) * nc;
                mid = r * nc;
                dn  = (r + 1) * nc;
                for (int c = 0; c < nc; c++) begin
                    cl = (c + nc - 1) % nc;
                    cr = (c + 1) % nc;
                    o  = cur[mid + c];
                    sd = cur[mid + cl] + cur[mid + cr] + cur[up + c] + cur[dn + c];
                    sg = cur[up + cl] + cur[up + cr] + cur[dn + cl] + cur[dn + cr];
                    nb = rnd16(sd * WDIR + sg * WDIAG);
                    kc = staged_cond[(r - 1) * nc + c];
                    nv = rnd16(o * kc + nb * (QONE - kc));
                    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                    nxt[mid + c] = nv;
                    d = (o > nv) ? o - nv : nv - o;
                    if (d > maxd) maxd = d;
                    if (!(d < longint'(thr))) conv = 1'b0;
                end
            end
            for (int p = nc; p < (nr + 1) * nc; p++) cur[p] = nxt[p];
            steps++;
        end while (steps < lim && !conv);
        mn  = 64'sd2147483647;
        mx  = -64'sd2147483648;
        sum = 0;
        for (int p = 0; p < rc; p++) begin
            sum += cur[nc + p];
            if (cur[nc + p] < mn) mn = cur[nc + p];
            if (cur[nc + p] > mx) mx = cur[nc + p];
        end
        if (sum > SUM_HI) sum = SUM_HI;
        if (sum < SUM_LO) sum = SUM_LO;
        if (maxd > 64'sd2147483647) maxd = 64'sd2147483647;
        s.iters = steps[23:0];
        s.mn    = mn[31:0];
        s.mx    = mx[31:0];
        s.sum   = sum[43:0];
        s.chg   = maxd[30:0];
        s.conv  = conv;
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_stats exp_s;
        longint k;
        if (!i_rst_n) begin
            load_pos = 0;
            thr      = 31'd6554;
            iter_lim = 24'd1000;
            rows_reg = 7'd64;
            cols_reg = 7'd64;
            fails    = 0;
            stats_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_THRESHOLD: thr = i_cfg_data;
                    REG_MAX_ITER:  iter_lim = i_cfg_data[23:0];
                    REG_ROWS:      rows_reg = i_cfg_data[6:0];
                    REG_COLS:      cols_reg = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (stats_q.size() == 0) begin
                    $error("unexpected result item");
                    fails++;
                end else begin
                    exp_s = stats_q.pop_front();
                    if (i_iterations_done !== exp_s.iters) begin
                        $error("iterations_done expected %0d got %0d",
                               exp_s.iters, i_iterations_done);
                        fails++;
                    end
                    if (i_min_temp !== exp_s.mn) begin
                        $error("min_temp expected %0d got %0d", exp_s.mn, i_min_temp);
                        fails++;
                    end
                    if (i_max_temp !== exp_s.mx) begin
                        $error("max_temp expected %0d got %0d", exp_s.mx, i_max_temp);
                        fails++;
                    end
                    if (i_sum_temp !== exp_s.sum) begin
                        $error("sum_temp expected %0d got %0d", exp_s.sum, i_sum_temp);
                        fails++;
                    end
                    if (i_max_change !== exp_s.chg) begin
                        $error("max_change expected %0d got %0d", exp_s.chg, i_max_change);
                        fails++;
                    end
                    if (i_converged !== exp_s.conv) begin
                        $error("converged expected %0d got %0d", exp_s.conv, i_converged);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                k = i_cell_conductivity;
                if (k > QONE) k = QONE;
                if (load_pos < CELLS) begin
                    staged_temp[load_pos] = i_cell_temperature;
                    staged_cond[load_pos] = k;
                    load_pos++;
                end
                if (i_last_cell) begin
                    stats_q.push_back(relax_grid());
                    load_pos = 0;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= stats_q.size();
    end
endmodule

### tb/tb_heat_stencil_relaxation.sv
// Testbench top: clock, reset, item and register stimulus, stall patterns and verdict
module tb_heat_stencil_relaxation;
    import hsr_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 4000;
    localparam int TALL_CELLS  = MAX_ROWS * 6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] cell_temp = '0;
    logic [16:0]        cell_cond = '0;
    logic               last_cell = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [23:0]        iters_done;
    logic signed [31:0] min_temp, max_temp;
    logic signed [43:0] sum_temp;
    logic [30:0]        max_change;
    logic               converged;
    logic               cfg_wr_en = 1'b0;
    t_reg               cfg_index = REG_THRESHOLD;
    logic [30:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_kick = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;
    int eff_rows = 64;
    int eff_cols = 64;
    int random_items = 0;

    always #10 i_clk = ~i_clk;

    heat_stencil_relaxation i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_cell_temperature(cell_temp), .i_cell_conductivity(cell_cond),
        .i_last_cell(last_cell),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_iterations_done(iters_done), .o_min_temp(min_temp), .o_max_temp(max_temp),
        .o_sum_temp(sum_temp), .o_max_change(max_change), .o_converged(converged),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    hsr_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_cell_temperature(cell_temp), .i_cell_conductivity(cell_cond),
        .i_last_cell(last_cell),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_iterations_done(iters_done), .i_min_temp(min_temp), .i_max_temp(max_temp),
        .i_sum_temp(sum_temp), .i_max_change(max_change), .i_converged(converged),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic load_cell(input logic [31:0] t, input logic [16:0] k, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        cell_temp <= t;
        cell_cond <= k;
        last_cell <= last;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [30:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [30:0] thr, input logic [23:0] lim,
                            input logic [6:0] r, input logic [6:0] c);
        drain_results();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MAX_ITER, {7'd0, lim});
        write_reg(REG_ROWS, {24'd0, r});
        write_reg(REG_COLS, {24'd0, c});
        cfg_wr_en <= 1'b0;
        eff_rows = (r < 1) ? 1 : ((r > MAX_ROWS) ? MAX_ROWS : r);
        eff_cols = (c < 2) ? 2 : ((c > MAX_COLS) ? MAX_COLS : c);
    endtask

    function automatic logic [31:0] pick_temp();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [16:0] pick_cond();
        case ($urandom_range(9))
            0: return $urandom_range(17'h1ffff, 17'h10001);
            1: return 17'h10000;
            2: return 17'h0;
            default: return $urandom_range(17'h10000);
        endcase
    endfunction

    task automatic random_run();
        int rc, n;
        rc = eff_rows * eff_cols;
        case ($urandom_range(9))
            0: n = $urandom_range(rc, 1);
            1: n = rc + $urandom_range(4, 1);
            default: n = rc;
        endcase
        for (int i = 0; i < n; i++) begin
            load_cell(pick_temp(), pick_cond(), i == n - 1);
            random_items++;
        end
    endtask

    task automatic random_config();
        logic [30:0] thr;
        logic [6:0]  r, c;
        case ($urandom_range(3))
            0: thr = 31'd0;
            1: thr = $urandom;
            default: thr = $urandom_range(20000);
        endcase
        r = $urandom_range(4);
        c = $urandom_range(6);
        case ($urandom_range(19))
            0: r = $urandom_range(127, 65);
            1: c = $urandom_range(127, 65);
            2: r = $urandom_range(64, 16);
            default: ;
        endcase
        if (c > 6 && r > 4) r = 2;
        set_grid(thr, $urandom_range(8), r, c);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the fields, conductivity above one
        set_grid(31'd0, 24'd3, 7'd2, 7'd2);
        load_cell(32'h7fff_ffff, 17'h00000, 1'b0);
        load_cell(32'h8000_0000, 17'h10000, 1'b0);
        load_cell(32'hffff_ffff, 17'h1ffff, 1'b0);
        load_cell(32'h0000_0000, 17'h00001, 1'b1);
        // short load
        load_cell(32'h0012_3456, 17'h08000, 1'b1);
        // zero sizes and zero iteration limit
        set_grid(31'd0, 24'd0, 7'd0, 7'd0);
        load_cell(32'h0001_0000, 17'h04000, 1'b0);
        load_cell(32'hfff0_0000, 17'h0c000, 1'b1);
        // oversized rows, single column, short load
        set_grid(31'h7fff_ffff, 24'd1, 7'd127, 7'd1);
        load_cell(32'h0100_0000, 17'h00000, 1'b0);
        load_cell(32'h8000_0000, 17'h10000, 1'b0);
        load_cell(32'h7fff_ffff, 17'h1ffff, 1'b1);
        // widest threshold with the largest iteration limit converges at once
        set_grid(31'h7fff_ffff, 24'hff_ffff, 7'd2, 7'd3);
        for (int i = 0; i < 6; i++) load_cell(i * 32'h100, 17'h08000, i == 5);
        // oversized columns
        set_grid(31'd100, 24'd2, 7'd1, 7'd127);
        for (int i = 0; i < 3; i++) load_cell(pick_temp(), pick_cond(), i == 2);
        // tallest grid, overlong load, lowest temperatures
        set_grid(31'd1, 24'd1, 7'd64, 7'd6);
        for (int i = 0; i < TALL_CELLS + 4; i++)
            load_cell(32'h8000_0000, 17'h10000, i == TALL_CELLS + 3);

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            while (random_items < (ph + 1) * 300) begin
                random_config();
                repeat ($urandom_range(5, 1)) random_run();
            end
        end

        // long receiver hold-off while the sender keeps offering items
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_grid(31'd500, 24'd4, 7'd3, 7'd3);
        hold_kick = hold_kick + 1;
        repeat (3) random_run();
        drain_results();
        random_run();
        drain_results();
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
